// ----- hdl/otft_pkg.sv -----
// ----------------------------------------------------------------------------
// otft_pkg - shared types and constants for the OOK tone frame transmitter
// Frame layout, tone ROM, register indexes and the records passed between
// the frame engine and the output register.
// ----------------------------------------------------------------------------
package otft_pkg;

    // frame and tone geometry
    localparam int FRAME_BITS  = 11;
    localparam int WAVE_POINTS = 64;
    localparam int ROM_SIZE    = 64;
    localparam int ROM_AW      = $clog2(ROM_SIZE);
    localparam int PHASE_W     = $clog2(WAVE_POINTS);
    localparam int BITS_W      = $clog2(FRAME_BITS + 1);

    // field widths
    localparam int CHAR_W  = 8;
    localparam int DAC_W   = 12;
    localparam int LEN_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_AW  = 1;

    // input word kinds
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_BIT_LENGTH = 1'd0;
    localparam logic [CFG_AW-1:0] REG_IDLE_LEVEL = 1'd1;

    // register reset values
    localparam logic [LEN_W-1:0] BIT_LENGTH_RST = 16'd1000;
    localparam logic [DAC_W-1:0] IDLE_LEVEL_RST = 12'd2048;

    // two sine periods, 32 points each
    localparam logic [DAC_W-1:0] TONE_ROM [ROM_SIZE] = '{
        12'd2048, 12'd2409, 12'd2756, 12'd3076, 12'd3356, 12'd3586, 12'd3757, 12'd3862,
        12'd3898, 12'd3862, 12'd3757, 12'd3586, 12'd3356, 12'd3076, 12'd2756, 12'd2409,
        12'd2048, 12'd1687, 12'd1340, 12'd1020, 12'd740,  12'd510,  12'd339,  12'd234,
        12'd198,  12'd234,  12'd339,  12'd510,  12'd740,  12'd1020, 12'd1340, 12'd1687,
        12'd2048, 12'd2409, 12'd2756, 12'd3076, 12'd3356, 12'd3586, 12'd3757, 12'd3862,
        12'd3898, 12'd3862, 12'd3757, 12'd3586, 12'd3356, 12'd3076, 12'd2756, 12'd2409,
        12'd2048, 12'd1687, 12'd1340, 12'd1020, 12'd740,  12'd510,  12'd339,  12'd234,
        12'd198,  12'd234,  12'd339,  12'd510,  12'd740,  12'd1020, 12'd1340, 12'd1687
    };

    // one accepted input word
    typedef struct packed {
        logic              cmd;
        logic [CHAR_W-1:0] char_data;
    } item_t;

    // one result word
    typedef struct packed {
        logic [DAC_W-1:0] dac_value;
        logic             dac_write;
        logic             request_next;
    } result_t;

endpackage

// ----- hdl/otft_frame_engine.sv -----
// ----------------------------------------------------------------------------
// otft_frame_engine - frame state and per-tick sample selection
// Holds the configuration registers and the frame/bit/tone state. Computes
// the result of the word in the input register and updates state on step.
// ----------------------------------------------------------------------------
module otft_frame_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [otft_pkg::CFG_AW-1:0]   cfg_index,
    input  logic [otft_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          step,
    input  otft_pkg::item_t               item,
    output otft_pkg::result_t             result
);

    logic [otft_pkg::LEN_W-1:0]      bit_length_reg;
    logic [otft_pkg::DAC_W-1:0]      idle_level_reg;

    logic [otft_pkg::FRAME_BITS-1:0] frame_shift_reg, frame_shift_next;
    logic [otft_pkg::BITS_W-1:0]     bits_left_reg, bits_left_next;
    logic                            current_bit_reg, current_bit_next;
    logic [otft_pkg::LEN_W-1:0]      ticks_left_reg, ticks_left_next;
    logic [otft_pkg::PHASE_W-1:0]    sine_phase_reg, sine_phase_next;

    logic [otft_pkg::ROM_AW-1:0]     rom_addr;

    assign rom_addr = otft_pkg::ROM_AW'(sine_phase_reg);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_length_reg <= otft_pkg::BIT_LENGTH_RST;
            idle_level_reg <= otft_pkg::IDLE_LEVEL_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                otft_pkg::REG_BIT_LENGTH: bit_length_reg <= cfg_wdata[otft_pkg::LEN_W-1:0];
                otft_pkg::REG_IDLE_LEVEL: idle_level_reg <= cfg_wdata[otft_pkg::DAC_W-1:0];
                default: ;
            endcase
        end
    end

    // next state and result for the current word
    always_comb begin
        frame_shift_next = frame_shift_reg;
        bits_left_next   = bits_left_reg;
        current_bit_next = current_bit_reg;
        ticks_left_next  = ticks_left_reg;
        sine_phase_next  = sine_phase_reg;
        result           = '0;

        if (item.cmd == otft_pkg::CMD_LOAD) begin
            // stop, data, parity, start - sent LSB first
            frame_shift_next = {1'b1, item.char_data, ^item.char_data, 1'b1};
            bits_left_next   = otft_pkg::BITS_W'(otft_pkg::FRAME_BITS);
        end else if (ticks_left_reg != '0) begin
            // bit on the air: tone for a one, idle level for a zero
            if (current_bit_reg) begin
                result.dac_value = otft_pkg::TONE_ROM[rom_addr];
                if (sine_phase_reg == otft_pkg::PHASE_W'(otft_pkg::WAVE_POINTS - 1)) begin
                    sine_phase_next = '0;
                end else begin
                    sine_phase_next = sine_phase_reg + 1'b1;
                end
            end else begin
                result.dac_value = idle_level_reg;
            end
            result.dac_write = 1'b1;
            ticks_left_next  = ticks_left_reg - 1'b1;
        end else if (bits_left_reg != '0) begin
            // fetch tick, no write
            current_bit_next = frame_shift_reg[0];
            ticks_left_next  = bit_length_reg;
            frame_shift_next = {1'b0, frame_shift_reg[otft_pkg::FRAME_BITS-1:1]};
            bits_left_next   = bits_left_reg - 1'b1;
        end else begin
            // idle: hold line and ask for a character
            result.dac_value    = idle_level_reg;
            result.dac_write    = 1'b1;
            result.request_next = 1'b1;
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_shift_reg <= '0;
            bits_left_reg   <= '0;
            current_bit_reg <= 1'b0;
            ticks_left_reg  <= '0;
            sine_phase_reg  <= '0;
        end else if (step) begin
            frame_shift_reg <= frame_shift_next;
            bits_left_reg   <= bits_left_next;
            current_bit_reg <= current_bit_next;
            ticks_left_reg  <= ticks_left_next;
            sine_phase_reg  <= sine_phase_next;
        end
    end

endmodule

// ----- hdl/otft_out_reg.sv -----
// ----------------------------------------------------------------------------
// otft_out_reg - result register on the master side
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module otft_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  otft_pkg::result_t  result,
    output logic               room,
    output logic               m_tvalid,
    input  logic               m_tready,
    output otft_pkg::result_t  held
);

    logic              valid_reg;
    otft_pkg::result_t data_reg;

    // free when empty or being drained this cycle
    assign room     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign held     = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (room) begin
            valid_reg <= load;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (load && room) begin
            data_reg <= result;
        end
    end

endmodule

// ----- hdl/ook_tone_frame_transmitter.sv -----
// ----------------------------------------------------------------------------
// ook_tone_frame_transmitter - on-off keyed tone serial transmitter
// Frames characters into 11-bit words and keys a sine tone per frame bit.
//
//   channel   dir  handshake          payload
//   s_        in   s_tvalid/s_tready  tuser = cmd, tdata = char_data
//   m_        out  m_tvalid/m_tready  tdata = dac_value, tuser = write/request
//   cfg_      in   cfg_wr_en          cfg_index, cfg_wdata
//
// A word sits in the input register while the combinational frame engine
// works on it; a tick's result word then goes into the result register and
// onto m_tvalid. A word can be accepted every cycle while no tick waits.
// Loads give no result word and pass even while the master side is stalled.
// A tick waits in the input register while the result register is full,
// holding s_tready low. Reset is synchronous, no sweep.
// ----------------------------------------------------------------------------
module ook_tone_frame_transmitter (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [otft_pkg::CFG_AW-1:0]   cfg_index,
    input  logic [otft_pkg::CFG_W-1:0]    cfg_wdata,
    // slave side
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] char_data
    input  logic                          s_tuser,   // [0] cmd
    // master side
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // [11:0] dac_value, [15:12] zero
    output logic [1:0]                    m_tuser    // [0] dac_write, [1] request_next
);

    logic              in_valid_reg;
    otft_pkg::item_t   in_item_reg;
    logic              room;
    logic              step;
    otft_pkg::result_t result;
    otft_pkg::result_t held;

    // a load needs no output slot, a tick needs one
    assign step     = in_valid_reg && ((in_item_reg.cmd == otft_pkg::CMD_LOAD) || room);
    assign s_tready = !in_valid_reg || step;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.cmd       <= s_tuser;
            in_item_reg.char_data <= s_tdata;
        end
    end

    otft_frame_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .item      (in_item_reg),
        .result    (result)
    );

    otft_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step && (in_item_reg.cmd == otft_pkg::CMD_TICK)),
        .result   (result),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .held     (held)
    );

    // pack result word
    assign m_tdata = {4'b0000, held.dac_value};
    assign m_tuser = {held.request_next, held.dac_write};

endmodule
